### hdl/cpfv_pkg.sv
package cpfv_pkg;

   localparam int CHAR_WIDTH  = 8;
   localparam int DIGIT_WIDTH = 4;
   localparam int COUNT_WIDTH = 4;
   localparam int ERR_WIDTH   = 3;
   localparam int PROD_WIDTH  = 8;

   localparam logic [CHAR_WIDTH-1:0]  CHAR_ZERO = 8'h30;
   localparam logic [CHAR_WIDTH-1:0]  CHAR_NINE = 8'h39;

   localparam logic [COUNT_WIDTH-1:0] CPF_LENGTH  = 4'd11;
   localparam logic [COUNT_WIDTH-1:0] COUNT_SAT   = 4'd12;
   localparam logic [COUNT_WIDTH-1:0] SUM1_DIGITS = 4'd9;
   localparam logic [COUNT_WIDTH-1:0] SUM2_DIGITS = 4'd10;
   localparam logic [COUNT_WIDTH-1:0] TENTH_POS   = 4'd9;
   localparam logic [COUNT_WIDTH-1:0] ELEVENTH_POS = 4'd10;
   localparam logic [DIGIT_WIDTH-1:0] WEIGHT1_TOP = 4'd10;
   localparam logic [DIGIT_WIDTH-1:0] WEIGHT2_TOP = 4'd11;
   localparam logic [DIGIT_WIDTH-1:0] MOD_BASE    = 4'd11;
   localparam logic [DIGIT_WIDTH-1:0] LOW_REM     = 4'd2;
   localparam logic [DIGIT_WIDTH-1:0] REPEAT_MIN  = 4'd2;

   localparam logic [ERR_WIDTH-1:0] ERR_NONE      = 3'd0;
   localparam logic [ERR_WIDTH-1:0] ERR_LENGTH    = 3'd1;
   localparam logic [ERR_WIDTH-1:0] ERR_REPEAT    = 3'd2;
   localparam logic [ERR_WIDTH-1:0] ERR_CHECK_ONE = 3'd3;
   localparam logic [ERR_WIDTH-1:0] ERR_CHECK_TWO = 3'd4;

   // classified character word passed from front to back
   typedef struct packed {
      logic                   is_digit;
      logic [DIGIT_WIDTH-1:0] digit;
      logic                   last;
   } word_type;

   // string state captured at the last character
   typedef struct packed {
      logic [COUNT_WIDTH-1:0] count;
      logic [DIGIT_WIDTH-1:0] rem_one;
      logic [DIGIT_WIDTH-1:0] rem_two;
      logic [DIGIT_WIDTH-1:0] tenth;
      logic [DIGIT_WIDTH-1:0] eleventh;
      logic [DIGIT_WIDTH-1:0] first;
      logic                   same;
   } finish_type;

   // remainder mod 11 of a value up to 109
   function automatic logic [DIGIT_WIDTH-1:0] mod11_small(input logic [PROD_WIDTH-1:0] v);
      logic [PROD_WIDTH-1:0] r;
      r = v;
      for (int k = 1; k <= 9; k++) begin
         if (v >= PROD_WIDTH'(11 * k)) begin
            r = v - PROD_WIDTH'(11 * k);
         end
      end
      return r[DIGIT_WIDTH-1:0];
   endfunction

   function automatic logic [DIGIT_WIDTH-1:0] check_digit(input logic [DIGIT_WIDTH-1:0] rem);
      return (rem < LOW_REM) ? '0 : (MOD_BASE - rem);
   endfunction

endpackage

### hdl/cpfv_front.sv
module cpfv_front
   import cpfv_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [CHAR_WIDTH-1:0] req_char_byte,
   input  logic                  req_last_char,
   output logic                  word_valid,
   input  logic                  word_ready,
   output word_type              word
);

   logic     valid_ff, valid_in;
   word_type word_ff, word_in;
   logic     is_digit;
   logic     accept;

   assign is_digit  = (req_char_byte >= CHAR_ZERO) && (req_char_byte <= CHAR_NINE);
   assign req_ready = !valid_ff || word_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff && !word_ready;
      word_in  = word_ff;
      if (accept) begin
         // non-digit that does not end the string carries nothing
         valid_in         = is_digit || req_last_char;
         word_in.is_digit = is_digit;
         word_in.digit    = DIGIT_WIDTH'(req_char_byte - CHAR_ZERO);
         word_in.last     = req_last_char;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
   end

   assign word_valid = valid_ff;
   assign word       = word_ff;

endmodule

### hdl/cpfv_queue.sv
module cpfv_queue
   import cpfv_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  word_type in_word,
   output logic     out_valid,
   input  logic     out_ready,
   output word_type out_word
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

   word_type        mem_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            push, pop;

   assign in_ready  = count_ff < CW'(DEPTH);
   assign out_valid = count_ff != '0;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_word  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_word;
      end
   end

endmodule

### hdl/cpfv_back.sv
module cpfv_back
   import cpfv_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   word_valid,
   output logic                   word_ready,
   input  word_type               word,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_is_valid,
   output logic [ERR_WIDTH-1:0]   rsp_error_code,
   output logic [COUNT_WIDTH-1:0] rsp_digits_seen
);

   // running string state, sums kept as remainders mod 11
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [DIGIT_WIDTH-1:0] rem_one_ff, rem_one_in;
   logic [DIGIT_WIDTH-1:0] rem_two_ff, rem_two_in;
   logic [DIGIT_WIDTH-1:0] tenth_ff, tenth_in;
   logic [DIGIT_WIDTH-1:0] eleventh_ff, eleventh_in;
   logic [DIGIT_WIDTH-1:0] first_ff, first_in;
   logic                   same_ff, same_in;

   logic                   fin_valid_ff, fin_valid_in;
   finish_type             fin_ff, fin_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   is_valid_ff;
   logic [ERR_WIDTH-1:0]   error_ff, error_in;
   logic [COUNT_WIDTH-1:0] seen_ff;

   logic                   out_free, fin_move, fin_free, take;
   logic [PROD_WIDTH-1:0]  prod_one, prod_two;
   logic [DIGIT_WIDTH-1:0] d;
   finish_type             upd;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign fin_move   = fin_valid_ff && out_free;
   assign fin_free   = !fin_valid_ff || fin_move;
   assign word_ready = !word.last || fin_free;
   assign take       = word_valid && word_ready;

   assign d        = word.digit;
   assign prod_one = PROD_WIDTH'(d) * PROD_WIDTH'(WEIGHT1_TOP - count_ff);
   assign prod_two = PROD_WIDTH'(d) * PROD_WIDTH'(WEIGHT2_TOP - count_ff);

   // state after taking this word's digit
   always_comb begin
      upd.count    = count_ff;
      upd.rem_one  = rem_one_ff;
      upd.rem_two  = rem_two_ff;
      upd.tenth    = tenth_ff;
      upd.eleventh = eleventh_ff;
      upd.first    = first_ff;
      upd.same     = same_ff;
      if (word.is_digit) begin
         if (count_ff < SUM1_DIGITS) begin
            upd.rem_one = mod11_small(PROD_WIDTH'(rem_one_ff) + prod_one);
         end
         if (count_ff < SUM2_DIGITS) begin
            upd.rem_two = mod11_small(PROD_WIDTH'(rem_two_ff) + prod_two);
         end
         if (count_ff == '0) begin
            upd.first = d;
         end else if (count_ff < CPF_LENGTH && d != first_ff) begin
            upd.same = 1'b0;
         end
         if (count_ff == TENTH_POS) begin
            upd.tenth = d;
         end
         if (count_ff == ELEVENTH_POS) begin
            upd.eleventh = d;
         end
         if (count_ff < COUNT_SAT) begin
            upd.count = count_ff + COUNT_WIDTH'(1);
         end
      end
   end

   always_comb begin
      count_in     = count_ff;
      rem_one_in   = rem_one_ff;
      rem_two_in   = rem_two_ff;
      tenth_in     = tenth_ff;
      eleventh_in  = eleventh_ff;
      first_in     = first_ff;
      same_in      = same_ff;
      fin_valid_in = fin_valid_ff && !fin_move;
      fin_in       = fin_ff;
      if (take) begin
         if (word.last) begin
            fin_valid_in = 1'b1;
            fin_in       = upd;
            count_in     = '0;
            rem_one_in   = '0;
            rem_two_in   = '0;
            tenth_in     = '0;
            eleventh_in  = '0;
            first_in     = '0;
            same_in      = 1'b1;
         end else begin
            count_in     = upd.count;
            rem_one_in   = upd.rem_one;
            rem_two_in   = upd.rem_two;
            tenth_in     = upd.tenth;
            eleventh_in  = upd.eleventh;
            first_in     = upd.first;
            same_in      = upd.same;
         end
      end
   end

   always_comb begin
      if (fin_ff.count != CPF_LENGTH) begin
         error_in = ERR_LENGTH;
      end else if (fin_ff.same && fin_ff.first >= REPEAT_MIN) begin
         error_in = ERR_REPEAT;
      end else if (check_digit(fin_ff.rem_one) != fin_ff.tenth) begin
         error_in = ERR_CHECK_ONE;
      end else if (check_digit(fin_ff.rem_two) != fin_ff.eleventh) begin
         error_in = ERR_CHECK_TWO;
      end else begin
         error_in = ERR_NONE;
      end
   end

   assign rsp_valid_in = fin_move || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rem_one_ff   <= '0;
         rem_two_ff   <= '0;
         tenth_ff     <= '0;
         eleventh_ff  <= '0;
         first_ff     <= '0;
         same_ff      <= 1'b1;
         fin_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rem_one_ff   <= rem_one_in;
         rem_two_ff   <= rem_two_in;
         tenth_ff     <= tenth_in;
         eleventh_ff  <= eleventh_in;
         first_ff     <= first_in;
         same_ff      <= same_in;
         fin_valid_ff <= fin_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      fin_ff <= fin_in;
      if (fin_move) begin
         is_valid_ff <= (error_in == ERR_NONE);
         error_ff    <= error_in;
         seen_ff     <= fin_ff.count;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_is_valid    = is_valid_ff;
   assign rsp_error_code  = error_ff;
   assign rsp_digits_seen = seen_ff;

endmodule

### hdl/cpf_check_digit_validator.sv
// CPF check-digit validator.
// req_ channel: one character word per transfer (req_char_byte), with
// req_last_char marking the end of the string. Non-digit characters are
// ignored; the count of digits saturates at 12.
// rsp_ channel: one word per string, sent after the last character:
// rsp_is_valid, rsp_error_code (0 ok, 1 length, 2 repeated digit,
// 3 first check digit, 4 second check digit) and rsp_digits_seen.
// Throughput: one character per cycle, sustained while rsp_ready is high.
// The front register, the queue and the accumulate stage each pass one
// word per cycle when not stalled. After the last character is accepted
// (the front register loads at the accepting edge), its word goes through
// the queue and the accumulate stage into the result register on rsp_.
// Reset clears the string state and empties all stages; no words are
// pending afterward. When rsp_ready is low the result register holds,
// the finish stage holds the next result, the following last character
// waits at the queue head, and req_ready drops once the queue and the
// front register are full; no word is lost.
module cpf_check_digit_validator
   import cpfv_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [CHAR_WIDTH-1:0]  req_char_byte,
   input  logic                   req_last_char,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_is_valid,
   output logic [ERR_WIDTH-1:0]   rsp_error_code,
   output logic [COUNT_WIDTH-1:0] rsp_digits_seen
);

   logic     front_valid, front_ready;
   word_type front_word;
   logic     back_valid, back_ready;
   word_type back_word;

   cpfv_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_byte (req_char_byte),
      .req_last_char (req_last_char),
      .word_valid    (front_valid),
      .word_ready    (front_ready),
      .word          (front_word)
   );

   cpfv_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_word   (front_word),
      .out_valid (back_valid),
      .out_ready (back_ready),
      .out_word  (back_word)
   );

   cpfv_back u_back (
      .clock           (clock),
      .reset           (reset),
      .word_valid      (back_valid),
      .word_ready      (back_ready),
      .word            (back_word),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_is_valid    (rsp_is_valid),
      .rsp_error_code  (rsp_error_code),
      .rsp_digits_seen (rsp_digits_seen)
   );

endmodule

### hdl/cpfv_checker.sv
module cpfv_checker
   import cpfv_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic [CHAR_WIDTH-1:0]  req_char_byte,
   input logic                   req_last_char,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic                   rsp_is_valid,
   input logic [ERR_WIDTH-1:0]   rsp_error_code,
   input logic [COUNT_WIDTH-1:0] rsp_digits_seen
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_is_valid)
         && $stable(rsp_error_code) && $stable(rsp_digits_seen))
      else $error("rsp word changed while stalled");

   a_valid_matches_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_is_valid == (rsp_error_code == ERR_NONE))
      else $error("is_valid disagrees with error code");

   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_error_code <= ERR_CHECK_TWO && rsp_digits_seen <= COUNT_SAT)
      else $error("result field out of range");

   a_length_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_error_code == ERR_LENGTH) == (rsp_digits_seen != CPF_LENGTH))
      else $error("length error inconsistent with digit count");

endmodule

bind cpf_check_digit_validator cpfv_checker u_checker (.*);
